### hdl/mic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants for the MIPS-I instruction core.
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam logic [31:0] VECTOR_ADDR = 32'h0000_003c;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic CFG_RESET_PC   = 1'b0;
    localparam logic CFG_PROCESS_ID = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DIVFIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic exec;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic div_finish;
    } t_cmd;

    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
    } t_status;

endpackage
`default_nettype wire

### hdl/mic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mic_ram
// Generic single-write RAM with registered read.
// ----------------------------------------------------------------------------
module mic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/mic_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mic_ctrl
// Sequencer for the instruction core: read, execute, multiply, divide, output.
// ----------------------------------------------------------------------------
module mic_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_out_free,
    input  wire  mic_pkg::t_status i_status,
    output logic                  o_in_ready,
    output logic                  o_out_load,
    output mic_pkg::t_cmd         o_cmd
);
    mic_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mic_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            mic_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state = mic_pkg::ST_READ;
                end
            end
            mic_pkg::ST_READ: begin
                n_state = mic_pkg::ST_EXEC;
            end
            mic_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_status.need_mul) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = mic_pkg::ST_MUL;
                end else if (i_status.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = mic_pkg::ST_DIV;
                end else begin
                    n_state = mic_pkg::ST_DONE;
                end
            end
            mic_pkg::ST_MUL: begin
                n_state = mic_pkg::ST_DONE;
            end
            mic_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = mic_pkg::ST_DIVFIN;
                end
            end
            mic_pkg::ST_DIVFIN: begin
                o_cmd.div_finish = 1'b1;
                n_state = mic_pkg::ST_DONE;
            end
            mic_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = mic_pkg::ST_IDLE;
                end
            end
            default: n_state = mic_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hdl/mic_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mic_dp
// Datapath: register file, pc, hi/lo, cop0 state, multiplier and divider.
// ----------------------------------------------------------------------------
module mic_dp (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire                    i_cfg_idx,
    input  wire  [31:0]            i_cfg_data,
    input  wire  mic_pkg::t_cmd    i_cmd,
    input  wire                    i_mode,
    input  wire  [31:0]            i_word,
    output mic_pkg::t_status       o_status,
    output logic [31:0]            o_fetch_address,
    output logic [1:0]             o_mem_op,
    output logic [31:0]            o_mem_address,
    output logic [1:0]             o_mem_size,
    output logic [31:0]            o_store_data,
    output logic                   o_exception_taken,
    output logic                   o_annulled,
    output logic                   o_halt_request,
    output logic                   o_sequence_error
);
    logic [10:0] r_pid;
    logic [31:0] r_hi, r_lo, r_pc, r_npc, r_epc;
    logic        r_status, r_user, r_skip, r_lpend;
    logic [4:0]  r_ltgt;
    logic [2:0]  r_lext;
    logic        r_mode;
    logic [31:0] r_word;
    logic [31:0] r_valid;

    // two read copies of the register file
    logic [31:0] w_ra, w_rb, w_a, w_b;
    logic        w_rf_we;
    logic [4:0]  w_rf_wa;
    logic [31:0] w_rf_wd;

    mic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_we(w_rf_we), .i_waddr(w_rf_wa), .i_wdata(w_rf_wd),
        .i_raddr(r_word[25:21]), .o_rdata(w_ra)
    );
    mic_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_we(w_rf_we), .i_waddr(w_rf_wa), .i_wdata(w_rf_wd),
        .i_raddr(r_word[20:16]), .o_rdata(w_rb)
    );

    assign w_a = r_valid[r_word[25:21]] ? w_ra : 32'd0;
    assign w_b = r_valid[r_word[20:16]] ? w_rb : 32'd0;

    // decode
    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_rs, w_rt, w_rd, w_sa;
    logic [31:0] w_imm, w_simm, w_addr;
    assign w_op   = r_word[31:26];
    assign w_rs   = r_word[25:21];
    assign w_rt   = r_word[20:16];
    assign w_rd   = r_word[15:11];
    assign w_sa   = r_word[10:6];
    assign w_fn   = r_word[5:0];
    assign w_imm  = {16'd0, r_word[15:0]};
    assign w_simm = {{16{r_word[15]}}, r_word[15:0]};
    assign w_addr = w_a + w_simm;

    // multiply / divide unit state
    logic [63:0] r_prod;
    logic        r_mul_signed;
    logic [31:0] r_quo, r_rem, r_dvs;
    logic [5:0]  r_dcnt;
    logic        r_dneg_q, r_dneg_r, r_dzero;
    logic [31:0] r_dividend;

    // execute result
    logic        e_we;
    logic [4:0]  e_wa;
    logic [31:0] e_wd;
    logic [31:0] e_npc_base, e_epc;
    logic        e_branch, e_likely_t, e_likely_nt, e_exc, e_halt;
    logic [1:0]  e_mop, e_msz;
    logic [31:0] e_saddr, e_sdata;
    logic        e_set_hi, e_set_lo, e_mul, e_mul_s, e_div, e_div_s;
    logic        e_cop_w, e_load;
    logic [2:0]  e_ext;
    logic [31:0] w_link, w_pc1, w_npc_new;
    logic [31:0] w_ld;
    logic        w_seqerr;

    assign w_seqerr = (r_mode != r_lpend);
    assign w_pc1    = r_npc;
    assign w_link   = r_npc + 32'd4;

    always_comb begin
        w_ld = r_word;
        unique case (r_lext[1:0])
            2'd0: w_ld = {{24{~r_lext[2] & r_word[7]}}, r_word[7:0]};
            2'd1: w_ld = {{16{~r_lext[2] & r_word[15]}}, r_word[15:0]};
            default: w_ld = r_word;
        endcase
    end

    always_comb begin
        e_we = 1'b0; e_wa = w_rd; e_wd = 32'd0;
        e_npc_base = w_link;
        e_epc = r_pc + 32'd4;
        if (r_npc != r_pc + 32'd4) e_epc[1] = 1'b1;
        e_branch = 1'b0; e_likely_t = 1'b0; e_likely_nt = 1'b0;
        e_exc = 1'b0; e_halt = 1'b0;
        e_mop = mic_pkg::MEM_NONE; e_msz = 2'd0; e_saddr = 32'd0; e_sdata = 32'd0;
        e_set_hi = 1'b0; e_set_lo = 1'b0;
        e_mul = 1'b0; e_mul_s = 1'b0; e_div = 1'b0; e_div_s = 1'b0;
        e_cop_w = 1'b0; e_load = 1'b0; e_ext = 3'd0;
        unique case (w_op)
            6'h00: begin
                unique case (w_fn)
                    6'h00: begin e_we = 1'b1; e_wd = w_b << w_sa; end
                    6'h02: begin e_we = 1'b1; e_wd = w_b >> w_sa; end
                    6'h03: begin e_we = 1'b1; e_wd = $signed(w_b) >>> w_sa; end
                    6'h04: begin e_we = 1'b1; e_wd = w_b << w_a[4:0]; end
                    6'h06: begin e_we = 1'b1; e_wd = w_b >> w_a[4:0]; end
                    6'h07: begin e_we = 1'b1; e_wd = $signed(w_b) >>> w_a[4:0]; end
                    6'h08: e_npc_base = w_a;
                    6'h09: begin e_npc_base = w_a; e_we = 1'b1; e_wd = w_link; end
                    6'h0a: begin e_we = (w_b == 32'd0); e_wd = w_a; end
                    6'h0b: begin e_we = (w_b != 32'd0); e_wd = w_a; end
                    6'h0c, 6'h0d: begin e_epc[0] = 1'b1; e_exc = 1'b1; end
                    6'h0f: e_halt = 1'b1;
                    6'h10: begin e_we = 1'b1; e_wd = r_hi; end
                    6'h11: e_set_hi = 1'b1;
                    6'h12: begin e_we = 1'b1; e_wd = r_lo; end
                    6'h13: e_set_lo = 1'b1;
                    6'h18: begin e_mul = 1'b1; e_mul_s = 1'b1; end
                    6'h19: e_mul = 1'b1;
                    6'h1a: begin e_div = 1'b1; e_div_s = 1'b1; end
                    6'h1b: e_div = 1'b1;
                    6'h20, 6'h21, 6'h2d: begin e_we = 1'b1; e_wd = w_a + w_b; end
                    6'h22, 6'h23: begin e_we = 1'b1; e_wd = w_a - w_b; end
                    6'h24: begin e_we = 1'b1; e_wd = w_a & w_b; end
                    6'h25: begin e_we = 1'b1; e_wd = w_a | w_b; end
                    6'h26: begin e_we = 1'b1; e_wd = w_a ^ w_b; end
                    6'h27: begin e_we = 1'b1; e_wd = ~(w_a | w_b); end
                    6'h2a: begin
                        e_we = 1'b1; e_wd = {31'd0, $signed(w_a) < $signed(w_b)};
                    end
                    6'h2b: begin e_we = 1'b1; e_wd = {31'd0, w_a < w_b}; end
                    6'h30, 6'h31, 6'h32, 6'h33, 6'h34, 6'h36: ;
                    default: e_halt = 1'b1;
                endcase
            end
            6'h01: begin
                e_wa = 5'd31; e_wd = w_link;
                unique case (w_rt)
                    5'h00, 5'h10: e_branch = w_a[31];
                    5'h01, 5'h11: e_branch = ~w_a[31];
                    5'h02, 5'h12: begin e_likely_t = w_a[31]; e_likely_nt = ~w_a[31]; end
                    5'h03, 5'h13: begin e_likely_t = ~w_a[31]; e_likely_nt = w_a[31]; end
                    5'h08, 5'h09, 5'h0a, 5'h0b, 5'h0c, 5'h0e: ;
                    default: e_halt = 1'b1;
                endcase
                e_we = w_rt[4] & (w_rt[3:2] == 2'd0);
            end
            6'h02: e_npc_base = {w_pc1[31:28], r_word[25:0], 2'b00};
            6'h03: begin
                e_npc_base = {w_pc1[31:28], r_word[25:0], 2'b00};
                e_we = 1'b1; e_wa = 5'd31; e_wd = w_link;
            end
            6'h04: e_branch = (w_a == w_b);
            6'h05: e_branch = (w_a != w_b);
            6'h06: e_branch = (w_a == 32'd0) | w_a[31];
            6'h07: e_branch = ~((w_a == 32'd0) | w_a[31]);
            6'h08, 6'h09: begin e_we = 1'b1; e_wa = w_rt; e_wd = w_a + w_simm; end
            6'h0a: begin
                e_we = 1'b1; e_wa = w_rt; e_wd = {31'd0, $signed(w_a) < $signed(w_simm)};
            end
            6'h0b: begin e_we = 1'b1; e_wa = w_rt; e_wd = {31'd0, w_a < w_simm}; end
            6'h0c: begin e_we = 1'b1; e_wa = w_rt; e_wd = w_a & w_imm; end
            6'h0d: begin e_we = 1'b1; e_wa = w_rt; e_wd = w_a | w_imm; end
            6'h0e: begin e_we = 1'b1; e_wa = w_rt; e_wd = w_a ^ w_imm; end
            6'h0f: begin e_we = 1'b1; e_wa = w_rt; e_wd = {r_word[15:0], 16'd0}; end
            6'h10: begin
                if (!r_word[23]) begin
                    e_we = 1'b1; e_wa = w_rt;
                    e_wd = (w_rd == 5'd12) ? {31'd0, r_status} : r_epc;
                end else begin
                    e_cop_w = 1'b1;
                end
            end
            6'h14: begin e_likely_t = (w_a == w_b); e_likely_nt = (w_a != w_b); end
            6'h15: begin e_likely_t = (w_a != w_b); e_likely_nt = (w_a == w_b); end
            6'h16: begin
                e_likely_t = (w_a == 32'd0) | w_a[31];
                e_likely_nt = ~e_likely_t;
            end
            6'h17: begin
                e_likely_nt = (w_a == 32'd0) | w_a[31];
                e_likely_t = ~e_likely_nt;
            end
            6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h30: begin
                unique case (w_op)
                    6'h20: e_ext = 3'd0;
                    6'h21: e_ext = 3'd1;
                    6'h24: e_ext = 3'd4;
                    6'h25: e_ext = 3'd5;
                    default: e_ext = 3'd2;
                endcase
                e_load = 1'b1;
                e_mop = mic_pkg::MEM_LOAD; e_saddr = w_addr; e_msz = e_ext[1:0];
            end
            6'h26, 6'h2e, 6'h2f: ;
            6'h28, 6'h29, 6'h2a, 6'h2b, 6'h38: begin
                e_mop = mic_pkg::MEM_STORE; e_saddr = w_addr; e_sdata = w_b;
                e_msz = (w_op == 6'h28) ? 2'd0 : (w_op == 6'h29) ? 2'd1 : 2'd2;
                if (w_op == 6'h38) begin
                    e_we = 1'b1; e_wa = w_rt; e_wd = 32'd1;
                end
            end
            default: e_halt = 1'b1;
        endcase
        w_npc_new = e_npc_base;
        if (e_branch || e_likely_t) w_npc_new = w_npc_new + {w_simm[29:0], 2'b00} - 32'd4;
        w_npc_new[1:0] = 2'b00;
    end

    // register file write: execute result or load return
    logic w_exec_ok, w_ldret;
    assign w_exec_ok = i_cmd.exec & ~w_seqerr & ~r_mode & ~r_skip;
    assign w_ldret   = i_cmd.exec & ~w_seqerr & r_mode;
    assign w_rf_we   = (w_exec_ok & e_we & (e_wa != 5'd0))
                     | (w_ldret & (r_ltgt != 5'd0));
    assign w_rf_wa   = r_mode ? r_ltgt : e_wa;
    assign w_rf_wd   = r_mode ? w_ld : e_wd;

    assign o_status.need_mul = w_exec_ok & e_mul;
    assign o_status.need_div = w_exec_ok & e_div & (w_b != 32'd0);
    assign o_status.div_last = (r_dcnt == 6'd31);

    // divider: restoring, one quotient bit per cycle
    logic [32:0] w_trial;
    assign w_trial = {r_rem, r_dividend[31]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_prod <= e_mul_s ? 64'($signed(w_a) * $signed(w_b)) : 64'(w_a * w_b);
        end
        if (i_cmd.div_start) begin
            r_dneg_q  <= e_div_s & (w_a[31] ^ w_b[31]);
            r_dneg_r  <= e_div_s & w_a[31];
            r_dividend <= (e_div_s & w_a[31]) ? 32'd0 - w_a : w_a;
            r_dvs     <= (e_div_s & w_b[31]) ? 32'd0 - w_b : w_b;
            r_rem     <= 32'd0;
            r_quo     <= 32'd0;
            r_dcnt    <= 6'd0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[30:0], 1'b0};
            if (!w_trial[32]) begin
                r_rem <= w_trial[31:0];
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[30:0], r_dividend[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 6'd1;
        end
        r_dzero <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid <= 11'd0; r_hi <= 32'd0; r_lo <= 32'd0;
            r_pc <= 32'd0; r_npc <= 32'd4; r_epc <= 32'd0;
            r_status <= 1'b0; r_user <= 1'b0; r_skip <= 1'b0;
            r_lpend <= 1'b0; r_ltgt <= 5'd0; r_lext <= 3'd0;
            r_valid <= 32'd0; r_mul_signed <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mic_pkg::CFG_RESET_PC) begin
                    r_pc <= i_cfg_data; r_npc <= i_cfg_data + 32'd4;
                end else begin
                    r_pid <= i_cfg_data[10:0];
                end
            end
            if (w_rf_we) r_valid[w_rf_wa] <= 1'b1;
            if (i_cmd.start) begin
                o_sequence_error <= 1'b0;
            end
            if (i_cmd.exec) begin
                o_fetch_address <= r_pc; o_mem_op <= mic_pkg::MEM_NONE;
                o_mem_address <= 32'd0; o_mem_size <= 2'd0; o_store_data <= 32'd0;
                o_exception_taken <= 1'b0; o_annulled <= 1'b0; o_halt_request <= 1'b0;
                o_sequence_error <= w_seqerr;
                if (w_ldret) r_lpend <= 1'b0;
                if (!w_seqerr && !r_mode) begin
                    r_pc <= r_npc;
                    o_fetch_address <= r_npc;
                    if (r_skip) begin
                        r_skip <= 1'b0; r_npc <= w_link; o_annulled <= 1'b1;
                    end else begin
                        r_npc <= w_npc_new;
                        r_skip <= e_likely_nt;
                        o_mem_op <= e_mop; o_mem_address <= e_saddr;
                        o_mem_size <= e_msz; o_store_data <= e_sdata;
                        o_halt_request <= e_halt;
                        if (e_set_hi) r_hi <= w_a;
                        if (e_set_lo) r_lo <= w_a;
                        if (e_mul) r_mul_signed <= e_mul_s;
                        if (e_div && w_b == 32'd0) begin
                            r_lo <= 32'hffff_ffff; r_hi <= w_a;
                        end
                        if (e_cop_w) begin
                            r_status <= w_b[0];
                            if (r_pid != 11'd0 && w_b[1]) r_user <= 1'b1;
                        end
                        if (e_load) begin
                            r_lpend <= 1'b1; r_ltgt <= w_rt; r_lext <= e_ext;
                        end
                        if (e_exc) begin
                            r_epc <= e_epc; r_npc <= mic_pkg::VECTOR_ADDR;
                            r_skip <= 1'b1; r_user <= 1'b0;
                            o_exception_taken <= 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.div_finish) begin
                r_lo <= r_dneg_q ? 32'd0 - r_quo : r_quo;
                r_hi <= r_dneg_r ? 32'd0 - r_rem : r_rem;
            end
            if (r_mul_signed | ~r_mul_signed) begin
                if (o_status.need_mul == 1'b0 && i_cmd.mul_start == 1'b0
                    && r_dzero == 1'b0 && i_cmd.div_step == 1'b0
                    && i_cmd.exec == 1'b0 && i_cmd.div_finish == 1'b0
                    && r_prod_pending) begin
                    r_hi <= r_prod[63:32]; r_lo <= r_prod[31:0];
                end
            end
        end
    end

    logic r_prod_pending;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_prod_pending <= 1'b0;
        else if (i_cmd.mul_start) r_prod_pending <= 1'b1;
        else if (!i_cmd.exec && !i_cmd.div_step && !i_cmd.div_finish) r_prod_pending <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode <= i_mode;
            r_word <= i_word;
        end
    end
endmodule
`default_nettype wire

### hdl/mips_instruction_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_instruction_core
// Multicycle MIPS-I integer core, one instruction word per item.
// Each item steps through accept, register read, execute and output;
// multiply adds the ST_MUL state, divide adds the bit-serial ST_DIV steps and ST_DIVFIN.
// One item at a time; the next item is accepted once the result is loaded.
// Synchronous active-low reset; pc restarts at zero, register file entries read zero until written.
// ----------------------------------------------------------------------------
module mips_instruction_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // word
    input  wire         s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // fetch_address[31:0], mem_op[33:32], mem_address[65:34], mem_size[67:66],
    // store_data[99:68], exception_taken[100], annulled[101],
    // halt_request[102], sequence_error[103]
    output logic [103:0] m_axis_tdata
);
    mic_pkg::t_cmd    w_cmd;
    mic_pkg::t_status w_status;
    logic        w_load;
    logic [31:0] w_fa, w_ma, w_sd;
    logic [1:0]  w_mo, w_ms;
    logic        w_ex, w_an, w_hr, w_se;

    mic_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_out_free(~m_axis_tvalid | m_axis_tready), .i_status(w_status),
        .o_in_ready(s_axis_tready), .o_out_load(w_load), .o_cmd(w_cmd)
    );

    mic_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx[0]), .i_cfg_data(i_cfg_data), .i_cmd(w_cmd),
        .i_mode(s_axis_tuser), .i_word(s_axis_tdata), .o_status(w_status),
        .o_fetch_address(w_fa), .o_mem_op(w_mo), .o_mem_address(w_ma),
        .o_mem_size(w_ms), .o_store_data(w_sd), .o_exception_taken(w_ex),
        .o_annulled(w_an), .o_halt_request(w_hr), .o_sequence_error(w_se)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_load) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            m_axis_tdata <= {w_se, w_hr, w_an, w_ex, w_sd, w_ms, w_ma, w_mo, w_fa};
        end
    end
endmodule
`default_nettype wire
